FILE: design/obbsat_pkg.sv
package obbsat_pkg;

  localparam int TRIG_LAT = 8;
  localparam int BACK_STAGES = 5;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;

  localparam logic [31:0] POLY_T1 = 32'd1686629713;
  localparam logic [31:0] POLY_T3 = 32'd693598669;
  localparam logic [31:0] POLY_T5 = 32'd85569306;
  localparam logic [31:0] POLY_T7 = 32'd5026995;
  localparam logic [31:0] POLY_T9 = 32'd172272;
  localparam logic [32:0] Q30_ONE = 33'd1 << 30;

  typedef enum logic [2:0] {
    REJ_NONE  = 3'd0,
    REJ_BROAD = 3'd1,
    REJ_A_X   = 3'd2,
    REJ_A_Y   = 3'd3,
    REJ_B_X   = 3'd4,
    REJ_B_Y   = 3'd5
  } reject_t;

endpackage

FILE: design/oriented_box_overlap_test.sv
// Oriented box overlap test: broad phase and separating axis test on two 2D boxes.
// An accepted item passes through the sine and cosine pipelines, then the queue, then
// the axis test stages. Throughput is one item per cycle while out_ready keeps the
// output moving; a 4-entry queue decouples the two halves.
// Reset is synchronous and active low; it clears the valid bits and queue pointers.
module oriented_box_overlap_test #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_first_center_x,
  input  logic signed [COORD_BITS-1:0] in_first_center_y,
  input  logic [COORD_BITS-2:0]        in_first_half_width,
  input  logic [COORD_BITS-2:0]        in_first_half_height,
  input  logic [ANGLE_BITS-1:0]        in_first_angle,
  input  logic signed [COORD_BITS-1:0] in_second_center_x,
  input  logic signed [COORD_BITS-1:0] in_second_center_y,
  input  logic [COORD_BITS-2:0]        in_second_half_width,
  input  logic [COORD_BITS-2:0]        in_second_half_height,
  input  logic [ANGLE_BITS-1:0]        in_second_angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_overlap,
  output logic [2:0]                   out_reject_stage
);

  localparam int SW = TRIG_FRACTION_BITS + 2;
  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS - 1;
  localparam int QW = 1 + 2 * DW + 4 * EW + 4 * SW;

  logic                 f_valid;
  logic                 f_ready;
  logic                 f_broad;
  logic signed [DW-1:0] f_dx;
  logic signed [DW-1:0] f_dy;
  logic [EW-1:0]        f_eax;
  logic [EW-1:0]        f_eay;
  logic [EW-1:0]        f_ebx;
  logic [EW-1:0]        f_eby;
  logic signed [SW-1:0] f_ca;
  logic signed [SW-1:0] f_sa;
  logic signed [SW-1:0] f_cb;
  logic signed [SW-1:0] f_sb;

  logic                 b_valid;
  logic                 b_ready;
  logic [QW-1:0]        q_in;
  logic [QW-1:0]        q_out;
  logic                 b_broad;
  logic signed [DW-1:0] b_dx;
  logic signed [DW-1:0] b_dy;
  logic [EW-1:0]        b_eax;
  logic [EW-1:0]        b_eay;
  logic [EW-1:0]        b_ebx;
  logic [EW-1:0]        b_eby;
  logic signed [SW-1:0] b_ca;
  logic signed [SW-1:0] b_sa;
  logic signed [SW-1:0] b_cb;
  logic signed [SW-1:0] b_sb;

  obbsat_front #(
    .COORD_BITS(COORD_BITS),
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .first_center_x(in_first_center_x),
    .first_center_y(in_first_center_y),
    .first_half_width(in_first_half_width),
    .first_half_height(in_first_half_height),
    .first_angle(in_first_angle),
    .second_center_x(in_second_center_x),
    .second_center_y(in_second_center_y),
    .second_half_width(in_second_half_width),
    .second_half_height(in_second_half_height),
    .second_angle(in_second_angle),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_broad(f_broad),
    .push_dx(f_dx),
    .push_dy(f_dy),
    .push_eax(f_eax),
    .push_eay(f_eay),
    .push_ebx(f_ebx),
    .push_eby(f_eby),
    .push_ca(f_ca),
    .push_sa(f_sa),
    .push_cb(f_cb),
    .push_sb(f_sb)
  );

  assign q_in = {f_broad, f_dx, f_dy, f_eax, f_eay, f_ebx, f_eby, f_ca, f_sa, f_cb, f_sb};

  obbsat_fifo #(.WIDTH(QW)) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data(q_in),
    .pop_valid(b_valid),
    .pop_ready(b_ready),
    .pop_data(q_out)
  );

  assign {b_broad, b_dx, b_dy, b_eax, b_eay, b_ebx, b_eby, b_ca, b_sa, b_cb, b_sb} = q_out;

  obbsat_back #(
    .COORD_BITS(COORD_BITS),
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .pop_valid(b_valid),
    .pop_ready(b_ready),
    .broad(b_broad),
    .dx(b_dx),
    .dy(b_dy),
    .eax(b_eax),
    .eay(b_eay),
    .ebx(b_ebx),
    .eby(b_eby),
    .ca(b_ca),
    .sa(b_sa),
    .cb(b_cb),
    .sb(b_sb),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_overlap(out_overlap),
    .out_reject_stage(out_reject_stage)
  );

endmodule

FILE: design/obbsat_trig.sv
module obbsat_trig #(
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [ANGLE_BITS-1:0]                angle,
  output logic signed [TRIG_FRACTION_BITS+1:0] value
);
  import obbsat_pkg::*;

  localparam int RW = ANGLE_BITS - 1;
  localparam int SW = TRIG_FRACTION_BITS + 2;
  localparam int MW = TRIG_FRACTION_BITS + 1;
  localparam logic [RW-1:0] QUARTER = RW'(1) << (ANGLE_BITS - 2);
  localparam logic [32:0] ROUND_HALF = 33'd1 << (29 - TRIG_FRACTION_BITS);

  logic [1:0]       quad;
  logic [RW-1:0]    rem;
  logic [RW-1:0]    rem_m;
  logic [30:0]      t_nxt;
  logic [61:0]      m1;
  logic [62:0]      m2;
  logic [62:0]      m3;
  logic [62:0]      m4;
  logic [62:0]      m5;
  logic [62:0]      m6;
  logic [32:0]      qc;
  logic [32:0]      rnd;
  logic [MW-1:0]    mag;
  logic signed [SW-1:0] value_nxt;

  logic [30:0]      t_r [6];
  logic [30:0]      t2_r [4];
  logic             neg_r [7];
  logic [31:0]      p7_r;
  logic [31:0]      p5_r;
  logic [31:0]      p3_r;
  logic [31:0]      p1_r;
  logic [32:0]      q_r;
  logic signed [SW-1:0] value_r;

  assign quad  = angle[ANGLE_BITS-1:ANGLE_BITS-2];
  assign rem   = {1'b0, angle[ANGLE_BITS-3:0]};
  assign rem_m = quad[0] ? RW'(QUARTER - rem) : rem;
  assign t_nxt = {rem_m, (32 - ANGLE_BITS)'(0)};

  assign m1 = 62'(t_r[0]) * 62'(t_r[0]);
  assign m2 = 63'(t2_r[0]) * 63'(POLY_T9);
  assign m3 = 63'(t2_r[1]) * 63'(p7_r);
  assign m4 = 63'(t2_r[2]) * 63'(p5_r);
  assign m5 = 63'(t2_r[3]) * 63'(p3_r);
  assign m6 = 63'(t_r[5]) * 63'(p1_r);

  assign qc  = (q_r > Q30_ONE) ? Q30_ONE : q_r;
  assign rnd = qc + ROUND_HALF;
  assign mag = rnd[30:30-TRIG_FRACTION_BITS];
  assign value_nxt = neg_r[6] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0]   <= t_nxt;
      neg_r[0] <= quad[1];
      for (int k = 1; k < 6; k++) begin
        t_r[k] <= t_r[k-1];
      end
      for (int k = 1; k < 7; k++) begin
        neg_r[k] <= neg_r[k-1];
      end
      t2_r[0] <= m1[60:30];
      for (int k = 1; k < 4; k++) begin
        t2_r[k] <= t2_r[k-1];
      end
      p7_r    <= 32'(POLY_T7 - m2[62:30]);
      p5_r    <= 32'(POLY_T5 - m3[62:30]);
      p3_r    <= 32'(POLY_T3 - m4[62:30]);
      p1_r    <= 32'(POLY_T1 - m5[62:30]);
      q_r     <= m6[62:30];
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

FILE: design/obbsat_front.sv
module obbsat_front #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16,
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_BITS-1:0]         first_center_x,
  input  logic signed [COORD_BITS-1:0]         first_center_y,
  input  logic [COORD_BITS-2:0]                first_half_width,
  input  logic [COORD_BITS-2:0]                first_half_height,
  input  logic [ANGLE_BITS-1:0]                first_angle,
  input  logic signed [COORD_BITS-1:0]         second_center_x,
  input  logic signed [COORD_BITS-1:0]         second_center_y,
  input  logic [COORD_BITS-2:0]                second_half_width,
  input  logic [COORD_BITS-2:0]                second_half_height,
  input  logic [ANGLE_BITS-1:0]                second_angle,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output logic                                 push_broad,
  output logic signed [COORD_BITS:0]           push_dx,
  output logic signed [COORD_BITS:0]           push_dy,
  output logic [COORD_BITS-2:0]                push_eax,
  output logic [COORD_BITS-2:0]                push_eay,
  output logic [COORD_BITS-2:0]                push_ebx,
  output logic [COORD_BITS-2:0]                push_eby,
  output logic signed [TRIG_FRACTION_BITS+1:0] push_ca,
  output logic signed [TRIG_FRACTION_BITS+1:0] push_sa,
  output logic signed [TRIG_FRACTION_BITS+1:0] push_cb,
  output logic signed [TRIG_FRACTION_BITS+1:0] push_sb
);
  import obbsat_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS - 1;
  localparam int XW = 1 + 2 * DW + 4 * EW;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic                 en;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [DW-1:0]        adx;
  logic [DW-1:0]        ady;
  logic [DW-1:0]        sumx;
  logic [DW-1:0]        sumy;
  logic                 broad;
  logic [XW-1:0]        side_nxt;
  logic [ANGLE_BITS-1:0] cos_angle_a;
  logic [ANGLE_BITS-1:0] cos_angle_b;

  logic [TRIG_LAT-1:0]  vld_r;
  logic [XW-1:0]        side_r [TRIG_LAT];

  assign en       = !vld_r[TRIG_LAT-1] || push_ready;
  assign in_ready = en;

  assign dx   = DW'(second_center_x) - DW'(first_center_x);
  assign dy   = DW'(second_center_y) - DW'(first_center_y);
  assign adx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ady  = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign sumx = DW'(first_half_width) + DW'(second_half_width);
  assign sumy = DW'(first_half_height) + DW'(second_half_height);
  assign broad = (adx > sumx) || (ady > sumy);
  assign side_nxt = {broad, dx, dy, first_half_width, first_half_height,
                     second_half_width, second_half_height};

  assign cos_angle_a = ANGLE_BITS'(first_angle + QUARTER);
  assign cos_angle_b = ANGLE_BITS'(second_angle + QUARTER);

  obbsat_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_sin_a (
    .clk(clk), .en(en), .angle(first_angle), .value(push_sa)
  );
  obbsat_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_cos_a (
    .clk(clk), .en(en), .angle(cos_angle_a), .value(push_ca)
  );
  obbsat_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_sin_b (
    .clk(clk), .en(en), .angle(second_angle), .value(push_sb)
  );
  obbsat_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_cos_b (
    .clk(clk), .en(en), .angle(cos_angle_b), .value(push_cb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TRIG_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < TRIG_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign push_valid = vld_r[TRIG_LAT-1];
  assign {push_broad, push_dx, push_dy, push_eax, push_eay, push_ebx, push_eby} =
    side_r[TRIG_LAT-1];

endmodule

FILE: design/obbsat_fifo.sv
module obbsat_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import obbsat_pkg::*;

  logic               push;
  logic               pop;
  logic [WIDTH-1:0]   mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign push_ready = (count_r != (FIFO_AW + 1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/obbsat_back.sv
module obbsat_back #(
  parameter int COORD_BITS = 16,
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 pop_valid,
  output logic                                 pop_ready,
  input  logic                                 broad,
  input  logic signed [COORD_BITS:0]           dx,
  input  logic signed [COORD_BITS:0]           dy,
  input  logic [COORD_BITS-2:0]                eax,
  input  logic [COORD_BITS-2:0]                eay,
  input  logic [COORD_BITS-2:0]                ebx,
  input  logic [COORD_BITS-2:0]                eby,
  input  logic signed [TRIG_FRACTION_BITS+1:0] ca,
  input  logic signed [TRIG_FRACTION_BITS+1:0] sa,
  input  logic signed [TRIG_FRACTION_BITS+1:0] cb,
  input  logic signed [TRIG_FRACTION_BITS+1:0] sb,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_overlap,
  output logic [2:0]                           out_reject_stage
);
  import obbsat_pkg::*;

  localparam int F  = TRIG_FRACTION_BITS;
  localparam int SW = F + 2;
  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS - 1;
  localparam int TP = 2 * SW;
  localparam int TS = TP + 1;
  localparam int DP = DW + SW;
  localparam int DS = DP + 1;
  localparam int RP = EW + SW;
  localparam logic [TS-1:0] HALF = TS'(1) << (F - 1);

  function automatic logic [SW-1:0] round_abs(input logic signed [TS-1:0] v);
    logic [TS-1:0] mag;
    logic [TS-1:0] sum;
    mag = v[TS-1] ? TS'(-v) : TS'(v);
    sum = mag + HALF;
    return sum[F+SW-1:F];
  endfunction

  function automatic logic [DS-1:0] dist_abs(input logic signed [DS-1:0] v);
    return v[DS-1] ? DS'(-v) : DS'(v);
  endfunction

  logic en;
  logic signed [TS-1:0] sum_pa;
  logic signed [TS-1:0] sum_pb;
  logic signed [TS-1:0] sum_d;
  logic signed [TS-1:0] sum_e;
  logic signed [DS-1:0] sum_da0;
  logic signed [DS-1:0] sum_da1;
  logic signed [DS-1:0] sum_db0;
  logic signed [DS-1:0] sum_db1;
  reject_t rej_nxt;

  logic [BACK_STAGES-1:0] vld_r;

  logic signed [TP-1:0] aa_c_r, aa_s_r, bb_c_r, bb_s_r, ab_cc_r, ab_ss_r, ab_cs_r, ab_sc_r;
  logic signed [DP-1:0] x_ca_r, y_sa_r, x_sa_r, y_ca_r, x_cb_r, y_sb_r, x_sb_r, y_cb_r;
  logic [EW-1:0] eax1_r, eay1_r, ebx1_r, eby1_r;
  logic [EW-1:0] eax2_r, eay2_r, ebx2_r, eby2_r;
  logic broad1_r, broad2_r, broad3_r, broad4_r;

  logic [SW-1:0] pa_r, pb_r, d_r, e_r;
  logic [DS-1:0] da0_2_r, da1_2_r, db0_2_r, db1_2_r;
  logic [DS-1:0] da0_3_r, da1_3_r, db0_3_r, db1_3_r;
  logic [DS-1:0] da0_4_r, da1_4_r, db0_4_r, db1_4_r;

  logic [RP-1:0] ax_pa_r, ay_pa_r, bx_d_r, by_e_r, bx_e_r, by_d_r;
  logic [RP-1:0] ax_d_r, ay_e_r, bx_pb_r, ax_e_r, ay_d_r, by_pb_r;

  logic [DS-1:0] ra0_r, ra1_r, rb0_r, rb1_r;

  reject_t rej_r;
  logic    overlap_r;

  assign en        = !vld_r[BACK_STAGES-1] || out_ready;
  assign pop_ready = en;

  assign sum_pa  = TS'(aa_c_r) + TS'(aa_s_r);
  assign sum_pb  = TS'(bb_c_r) + TS'(bb_s_r);
  assign sum_d   = TS'(ab_cc_r) + TS'(ab_ss_r);
  assign sum_e   = TS'(ab_sc_r) - TS'(ab_cs_r);
  assign sum_da0 = DS'(x_ca_r) + DS'(y_sa_r);
  assign sum_da1 = DS'(y_ca_r) - DS'(x_sa_r);
  assign sum_db0 = DS'(x_cb_r) + DS'(y_sb_r);
  assign sum_db1 = DS'(y_cb_r) - DS'(x_sb_r);

  always_comb begin
    if (broad4_r) begin
      rej_nxt = REJ_BROAD;
    end else if (da0_4_r > ra0_r) begin
      rej_nxt = REJ_A_X;
    end else if (da1_4_r > ra1_r) begin
      rej_nxt = REJ_A_Y;
    end else if (db0_4_r > rb0_r) begin
      rej_nxt = REJ_B_X;
    end else if (db1_4_r > rb1_r) begin
      rej_nxt = REJ_B_Y;
    end else begin
      rej_nxt = REJ_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[BACK_STAGES-2:0], pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aa_c_r  <= ca * ca;
      aa_s_r  <= sa * sa;
      bb_c_r  <= cb * cb;
      bb_s_r  <= sb * sb;
      ab_cc_r <= ca * cb;
      ab_ss_r <= sa * sb;
      ab_cs_r <= ca * sb;
      ab_sc_r <= sa * cb;
      x_ca_r  <= dx * ca;
      y_sa_r  <= dy * sa;
      x_sa_r  <= dx * sa;
      y_ca_r  <= dy * ca;
      x_cb_r  <= dx * cb;
      y_sb_r  <= dy * sb;
      x_sb_r  <= dx * sb;
      y_cb_r  <= dy * cb;
      eax1_r  <= eax;
      eay1_r  <= eay;
      ebx1_r  <= ebx;
      eby1_r  <= eby;
      broad1_r <= broad;

      pa_r    <= round_abs(sum_pa);
      pb_r    <= round_abs(sum_pb);
      d_r     <= round_abs(sum_d);
      e_r     <= round_abs(sum_e);
      da0_2_r <= dist_abs(sum_da0);
      da1_2_r <= dist_abs(sum_da1);
      db0_2_r <= dist_abs(sum_db0);
      db1_2_r <= dist_abs(sum_db1);
      eax2_r  <= eax1_r;
      eay2_r  <= eay1_r;
      ebx2_r  <= ebx1_r;
      eby2_r  <= eby1_r;
      broad2_r <= broad1_r;

      ax_pa_r <= eax2_r * pa_r;
      ay_pa_r <= eay2_r * pa_r;
      bx_d_r  <= ebx2_r * d_r;
      by_e_r  <= eby2_r * e_r;
      bx_e_r  <= ebx2_r * e_r;
      by_d_r  <= eby2_r * d_r;
      ax_d_r  <= eax2_r * d_r;
      ay_e_r  <= eay2_r * e_r;
      bx_pb_r <= ebx2_r * pb_r;
      ax_e_r  <= eax2_r * e_r;
      ay_d_r  <= eay2_r * d_r;
      by_pb_r <= eby2_r * pb_r;
      da0_3_r <= da0_2_r;
      da1_3_r <= da1_2_r;
      db0_3_r <= db0_2_r;
      db1_3_r <= db1_2_r;
      broad3_r <= broad2_r;

      ra0_r   <= DS'(ax_pa_r) + DS'(bx_d_r) + DS'(by_e_r);
      ra1_r   <= DS'(ay_pa_r) + DS'(bx_e_r) + DS'(by_d_r);
      rb0_r   <= DS'(ax_d_r) + DS'(ay_e_r) + DS'(bx_pb_r);
      rb1_r   <= DS'(ax_e_r) + DS'(ay_d_r) + DS'(by_pb_r);
      da0_4_r <= da0_3_r;
      da1_4_r <= da1_3_r;
      db0_4_r <= db0_3_r;
      db1_4_r <= db1_3_r;
      broad4_r <= broad3_r;

      rej_r     <= rej_nxt;
      overlap_r <= (rej_nxt == REJ_NONE);
    end
  end

  assign out_valid        = vld_r[BACK_STAGES-1];
  assign out_overlap      = overlap_r;
  assign out_reject_stage = rej_r;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

class overlap_scoreboard;
  typedef struct packed {
    logic       overlap;
    logic [2:0] stage;
  } verdict_t;

  verdict_t pending[$];
  int       errors;

  function automatic longint sine_q(longint unsigned ang);
    longint unsigned a, quad, r, t, t2, p, m;
    a = ang & 64'hffff;
    quad = (a >> 14) & 3;
    r = a & 64'h3fff;
    if (quad[0]) r = 64'h4000 - r;
    t = r << 16;
    t2 = (t * t) >> 30;
    p = 64'd5026995 - ((t2 * 64'd172272) >> 30);
    p = 64'd85569306 - ((t2 * p) >> 30);
    p = 64'd693598669 - ((t2 * p) >> 30);
    p = 64'd1686629713 - ((t2 * p) >> 30);
    p = (t * p) >> 30;
    if (p > (64'd1 << 30)) p = 64'd1 << 30;
    m = (p + (64'd1 << 14)) >> 15;
    return quad[1] ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint adot(longint px, longint py, longint qx, longint qy);
    return (mag(px * qx + py * qy) + (64'd1 << 14)) >> 15;
  endfunction

  function automatic bit axis_ok(longint nx, longint ny, longint ax[6], longint bx[6]);
    longint reach, sep;
    reach = ax[2] * adot(nx, ny, ax[4], ax[5]) + ax[3] * adot(nx, ny, -ax[5], ax[4])
          + bx[2] * adot(nx, ny, bx[4], bx[5]) + bx[3] * adot(nx, ny, -bx[5], bx[4]);
    sep = mag((bx[0] - ax[0]) * nx + (bx[1] - ax[1]) * ny);
    return sep <= reach;
  endfunction

  // Box vector: cx, cy, ex, ey, cos, sin.
  function void note_pair(logic signed [15:0] acx, acy, logic [14:0] aex, aey,
                          logic [15:0] aang, logic signed [15:0] bcx, bcy,
                          logic [14:0] bex, bey, logic [15:0] bang);
    longint   a[6], b[6];
    verdict_t v;
    a = '{acx, acy, aex, aey, sine_q(aang + 16'h4000), sine_q(aang)};
    b = '{bcx, bcy, bex, bey, sine_q(bang + 16'h4000), sine_q(bang)};
    if (mag(a[0] - b[0]) > a[2] + b[2] || mag(a[1] - b[1]) > a[3] + b[3])
      v.stage = obbsat_pkg::REJ_BROAD;
    else if (!axis_ok(a[4], a[5], a, b)) v.stage = obbsat_pkg::REJ_A_X;
    else if (!axis_ok(-a[5], a[4], a, b)) v.stage = obbsat_pkg::REJ_A_Y;
    else if (!axis_ok(b[4], b[5], a, b)) v.stage = obbsat_pkg::REJ_B_X;
    else if (!axis_ok(-b[5], b[4], a, b)) v.stage = obbsat_pkg::REJ_B_Y;
    else v.stage = obbsat_pkg::REJ_NONE;
    v.overlap = (v.stage == obbsat_pkg::REJ_NONE);
    pending.push_back(v);
  endfunction

  function void check_verdict(logic ov, logic [2:0] st);
    verdict_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result overlap=%0d stage=%0d", $time, ov, st);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (ov !== e.overlap) begin
      $display("%0t: overlap expected %0d actual %0d", $time, e.overlap, ov);
      errors++;
    end
    if (st !== e.stage) begin
      $display("%0t: reject_stage expected %0d actual %0d", $time, e.stage, st);
      errors++;
    end
  endfunction
endclass

module tb;
  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] acx = 0, acy = 0, bcx = 0, bcy = 0;
  logic [14:0] aex = 0, aey = 0, bex = 0, bey = 0;
  logic [15:0] aang = 0, bang = 0;
  logic out_valid;
  logic out_ready = 0;
  logic out_overlap;
  logic [2:0] out_reject_stage;
  logic hold_off = 0;
  int gap_left = 0;
  int burst_left = 0;
  bit sending_done = 0;

  overlap_scoreboard board = new();

  always #4 clk = ~clk;

  oriented_box_overlap_test i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_center_x(acx), .in_first_center_y(acy),
    .in_first_half_width(aex), .in_first_half_height(aey), .in_first_angle(aang),
    .in_second_center_x(bcx), .in_second_center_y(bcy),
    .in_second_half_width(bex), .in_second_half_height(bey), .in_second_angle(bang),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_overlap(out_overlap), .out_reject_stage(out_reject_stage)
  );

  task automatic send_pair(logic signed [15:0] x0, y0, logic [14:0] w0, h0, logic [15:0] g0,
                           logic signed [15:0] x1, y1, logic [14:0] w1, h1,
                           logic [15:0] g1);
    while (gap_left > 0) begin
      in_valid <= 0;
      gap_left--;
      @(posedge clk);
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    end
    burst_left--;
    in_valid <= 1;
    acx <= x0; acy <= y0; aex <= w0; aey <= h0; aang <= g0;
    bcx <= x1; bcy <= y1; bex <= w1; bey <= h1; bang <= g1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_pair(x0, y0, w0, h0, g0, x1, y1, w1, h1, g1);
  endtask

  task automatic send_random();
    logic signed [15:0] x0, y0, dx, dy;
    logic [14:0] w0, h0, w1, h1;
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      // Nearby pairs with moderate sizes exercise the axis stages.
      w0 = 15'($urandom_range(0, 2000)); h0 = 15'($urandom_range(0, 2000));
      w1 = 15'($urandom_range(0, 2000)); h1 = 15'($urandom_range(0, 2000));
      x0 = 16'($urandom); y0 = 16'($urandom);
      dx = 16'($signed($urandom_range(0, 6000)) - 3000);
      dy = 16'($signed($urandom_range(0, 6000)) - 3000);
      send_pair(x0, y0, w0, h0, 16'($urandom), x0 + dx, y0 + dy, w1, h1, 16'($urandom));
    end else begin
      send_pair(16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 16, 16, 0, 32, 0, 16, 16, 0);
    send_pair(0, 0, 16, 16, 0, 33, 0, 16, 16, 0);
    send_pair(-32768, -32768, 32767, 32767, 16'hffff, 32767, 32767, 32767, 32767, 0);
    send_pair(32767, -32768, 0, 0, 16'h8000, -32768, 32767, 32767, 32767, 16'h4000);
    send_pair(0, 0, 100, 10, 16'h2000, 100, 100, 100, 10, 16'h2000);
    send_pair(0, 0, 100, 10, 16'h2000, 60, -60, 10, 10, 0);
    send_pair(0, 0, 10, 10, 0, 19, 19, 10, 10, 16'h2000);
    send_pair(0, 0, 10, 10, 16'h2000, 19, 19, 10, 10, 0);
    send_pair(0, 0, 200, 5, 16'h1000, 150, 20, 200, 5, 16'hd000);
    send_pair(5, 5, 32767, 0, 16'h4000, 5, 5, 0, 32767, 16'hc000);
    send_pair(0, 0, 0, 0, 16'h7fff, 0, 0, 0, 0, 16'hbfff);
    send_pair(0, 0, 20000, 20000, 16'h5555, -32768, 0, 0, 0, 16'haaaa);
    for (int i = 0; i < 450; i++) send_random();
    in_valid <= 0;
    sending_done = 1;
  end

  initial begin
    repeat (300) @(posedge clk);
    hold_off <= 1;
    repeat (60) @(posedge clk);
    hold_off <= 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) board.check_verdict(out_overlap, out_reject_stage);
      out_ready <= !hold_off && ($urandom_range(0, 3) != 0 || $time % 2000 < 400);
    end
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

FILE: files.f
design/obbsat_pkg.sv
design/obbsat_trig.sv
design/obbsat_front.sv
design/obbsat_fifo.sv
design/obbsat_back.sv
design/oriented_box_overlap_test.sv
tb/tb.sv
